// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define HDTU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define HDTU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hdtu_pkg.sv =====
// types, codes and reset constants for the half-duplex timed serial port
// no dependencies
`default_nettype none

package hdtu_pkg;

    localparam int unsigned TimerWidth = 17;
    localparam int unsigned ByteWidth  = 8;

    typedef logic [TimerWidth-1:0] period_t;
    typedef logic [ByteWidth-1:0]  byte_t;

    // input word operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SEND    = 2'd1,
        OP_RX_MODE = 2'd2,
        OP_TX_MODE = 2'd3
    } opcode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BIT_PERIOD      = 2'd0,
        REG_HUNT_PERIOD     = 2'd1,
        REG_RX_FIRST_PERIOD = 2'd2,
        REG_TX_START_PERIOD = 2'd3
    } reg_index_t;

    localparam period_t BIT_PERIOD_RST      = period_t'(2000);
    localparam period_t HUNT_PERIOD_RST     = period_t'(501);
    localparam period_t RX_FIRST_PERIOD_RST = period_t'(1984);
    localparam period_t TX_START_PERIOD_RST = period_t'(1961);

    // frame bookkeeping
    localparam byte_t TX_FRAME_COUNT = byte_t'(10);
    localparam byte_t LAST_DATA_BIT  = byte_t'(9);
    localparam byte_t STOP_FILL      = byte_t'(8'hFF);

    typedef struct packed {
        period_t bit_period;
        period_t hunt_period;
        period_t rx_first_period;
        period_t tx_start_period;
    } periods_t;

    typedef struct packed {
        logic  tx_line;
        logic  tx_done;
        logic  rx_valid;
        byte_t rx_data;
        logic  receive_on;
        logic  transmit_on;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/hdtu_cfg.sv =====
// configuration register file holding the four timer periods
// depends on hdtu_pkg
`default_nettype none

module hdtu_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire hdtu_pkg::period_t   cfg_data,
    output hdtu_pkg::periods_t       periods
);
    import hdtu_pkg::*;

    periods_t periods_reg;
    periods_t periods_next;

    assign cfg_ready = 1'b1;
    assign periods   = periods_reg;

    // register write decode
    always_comb
    begin
        periods_next = periods_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BIT_PERIOD:      periods_next.bit_period      = cfg_data;
                REG_HUNT_PERIOD:     periods_next.hunt_period     = cfg_data;
                REG_RX_FIRST_PERIOD: periods_next.rx_first_period = cfg_data;
                REG_TX_START_PERIOD: periods_next.tx_start_period = cfg_data;
                default:             periods_next = periods_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periods_reg.bit_period      <= BIT_PERIOD_RST;
            periods_reg.hunt_period     <= HUNT_PERIOD_RST;
            periods_reg.rx_first_period <= RX_FIRST_PERIOD_RST;
            periods_reg.tx_start_period <= TX_START_PERIOD_RST;
        end
        else
        begin
            periods_reg <= periods_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hdtu_core.sv =====
// input register, port state and single-pass step logic
// depends on hdtu_pkg
`default_nettype none

module hdtu_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          opcode,
    input  wire logic                rx_line,
    input  wire hdtu_pkg::byte_t     tx_data,
    input  wire hdtu_pkg::periods_t  periods,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output hdtu_pkg::result_t        res
);
    import hdtu_pkg::*;

    // input register
    logic    in_valid_reg;
    opcode_t opcode_reg;
    logic    rx_line_reg;
    byte_t   tx_data_reg;

    // port state
    logic    rx_enabled_reg,  rx_enabled_next;
    logic    tx_enabled_reg,  tx_enabled_next;
    byte_t   bit_count_reg,   bit_count_next;
    byte_t   shift_reg,       shift_next;
    period_t timer_reg,       timer_next;
    logic    line_out_reg,    line_out_next;
    logic    done_reg,        done_next;

    logic    rx_valid;
    byte_t   rx_byte;
    byte_t   count_up;
    byte_t   count_down;
    byte_t   rx_shift;
    logic    step;

    assign step     = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || res_ready;

    assign count_up   = bit_count_reg + byte_t'(1);
    assign count_down = bit_count_reg - byte_t'(1);
    assign rx_shift   = {rx_line_reg, shift_reg[ByteWidth-1:1]};

    // next state for one word
    always_comb
    begin
        rx_enabled_next = rx_enabled_reg;
        tx_enabled_next = tx_enabled_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        timer_next      = timer_reg;
        line_out_next   = line_out_reg;
        done_next       = done_reg;
        rx_valid        = 1'b0;
        rx_byte         = '0;
        case (opcode_reg)
            OP_TICK:
            begin
                if (rx_enabled_reg || tx_enabled_reg)
                begin
                    if (timer_reg > period_t'(1))
                    begin
                        timer_next = timer_reg - period_t'(1);
                    end
                    else if (rx_line_reg && (bit_count_reg == '0))
                    begin
                        timer_next = periods.hunt_period;
                    end
                    else if (rx_enabled_reg)
                    begin
                        // receiver event
                        if (bit_count_reg == '0)
                        begin
                            timer_next     = periods.rx_first_period;
                            bit_count_next = byte_t'(1);
                            shift_next     = '0;
                        end
                        else if (count_up <= LAST_DATA_BIT)
                        begin
                            timer_next     = periods.bit_period;
                            bit_count_next = count_up;
                            shift_next     = rx_shift;
                            rx_valid       = (count_up == LAST_DATA_BIT);
                            rx_byte        = rx_valid ? rx_shift : '0;
                        end
                        else
                        begin
                            // stop-bit slot, back to hunting
                            timer_next     = periods.hunt_period;
                            bit_count_next = '0;
                        end
                    end
                    else
                    begin
                        // transmitter event
                        timer_next     = periods.bit_period;
                        bit_count_next = count_down;
                        if (count_down > LAST_DATA_BIT)
                        begin
                            bit_count_next = LAST_DATA_BIT;
                            shift_next     = STOP_FILL;
                        end
                        if (bit_count_next > byte_t'(1))
                        begin
                            line_out_next = shift_next[0];
                            shift_next    = {1'b0, shift_next[ByteWidth-1:1]};
                        end
                        else
                        begin
                            line_out_next = 1'b1;
                            if (bit_count_next == '0)
                            begin
                                done_next = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_SEND:
            begin
                if (tx_enabled_reg && done_reg)
                begin
                    timer_next     = periods.tx_start_period;
                    shift_next     = tx_data_reg;
                    bit_count_next = TX_FRAME_COUNT;
                    line_out_next  = 1'b0;
                    done_next      = 1'b0;
                end
            end
            OP_RX_MODE:
            begin
                rx_enabled_next = 1'b1;
                tx_enabled_next = 1'b0;
                timer_next      = periods.hunt_period;
                bit_count_next  = '0;
            end
            default:
            begin
                tx_enabled_next = 1'b1;
                rx_enabled_next = 1'b0;
                bit_count_next  = '0;
                done_next       = 1'b1;
            end
        endcase
    end

    // result word handed to the output buffer
    assign res_valid       = in_valid_reg;
    assign res.tx_line     = line_out_next;
    assign res.tx_done     = done_next;
    assign res.rx_valid    = rx_valid;
    assign res.rx_data     = rx_byte;
    assign res.receive_on  = rx_enabled_next;
    assign res.transmit_on = tx_enabled_next;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            opcode_reg  <= opcode_t'(opcode);
            rx_line_reg <= rx_line;
            tx_data_reg <= tx_data;
        end
    end

    // port state, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enabled_reg <= 1'b0;
            tx_enabled_reg <= 1'b0;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            timer_reg      <= HUNT_PERIOD_RST;
            line_out_reg   <= 1'b1;
            done_reg       <= 1'b0;
        end
        else if (step)
        begin
            rx_enabled_reg <= rx_enabled_next;
            tx_enabled_reg <= tx_enabled_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            timer_reg      <= timer_next;
            line_out_reg   <= line_out_next;
            done_reg       <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hdtu_obuf.sv =====
// result register with a skid stage so the core keeps going under a stall
// depends on hdtu_pkg
`default_nettype none

module hdtu_obuf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire hdtu_pkg::result_t   up_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hdtu_pkg::result_t        out_data
);
    import hdtu_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take;
    logic    push;

    assign up_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign take      = out_valid_reg && out_ready;
    assign push      = up_valid && up_ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_reg <= up_data;
            end
            else
            begin
                skid_data_reg <= up_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/half_duplex_timed_uart_unit.sv =====
// Half-duplex 8N1 serial port paced by a down-counting interval timer.
// Three channels, each valid/ready. The config channel writes one of four
// 17-bit periods (bit, hunt, first receive sample, transmit start bit) by
// index; it is always ready and should only be used while the port is idle.
// The input channel takes one word per cycle while ready: a tick carrying
// the sampled receive level, a send-byte command, or a receive/transmit
// mode switch. Every input word gives exactly one result word on the
// output channel, carrying the transmit level, done flag, received byte
// strobe and data, and the two mode bits as they stand after that word.
// Each word is held in the input register, then goes through the step
// logic into the result register. Throughput is one word per cycle while
// the output is not stalled; the port registers step once per word.
// When the receiver stalls, a one-word skid stage absorbs the word in
// flight and the input channel drops ready until the skid drains.
// Reset loads the default periods, turns both modes off, drives the
// transmit line high and preloads the timer with the hunt period.
// depends on hdtu_pkg, hdtu_cfg, hdtu_core, hdtu_obuf
`default_nettype none

module half_duplex_timed_uart_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire hdtu_pkg::period_t   cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          opcode,
    input  wire logic                rx_line,
    input  wire hdtu_pkg::byte_t     tx_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     tx_line,
    output logic                     tx_done,
    output logic                     rx_valid,
    output hdtu_pkg::byte_t          rx_data,
    output logic                     receive_on,
    output logic                     transmit_on
);
    import hdtu_pkg::*;

    periods_t periods;
    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  out_data;

    // period registers
    hdtu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .periods   (periods)
    );

    // port state and step logic
    hdtu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .rx_line   (rx_line),
        .tx_data   (tx_data),
        .periods   (periods),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register and skid
    hdtu_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (res_valid),
        .up_ready  (res_ready),
        .up_data   (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign tx_line     = out_data.tx_line;
    assign tx_done     = out_data.tx_done;
    assign rx_valid    = out_data.rx_valid;
    assign rx_data     = out_data.rx_data;
    assign receive_on  = out_data.receive_on;
    assign transmit_on = out_data.transmit_on;

endmodule

`default_nettype wire

// ===== rtl/hdtu_checker.sv =====
// port-level checks for the serial port, bound to the top level
// depends on hdtu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hdtu_port_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              rx_valid,
    input  wire hdtu_pkg::byte_t   rx_data,
    input  wire logic              receive_on,
    input  wire logic              transmit_on
);
    import hdtu_pkg::*;

    // a stalled result word stays offered
    `HDTU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")

    // the two modes never both on
    `HDTU_ASSERT(a_mode_excl, clk, rst_n, out_valid |-> !(receive_on && transmit_on), "receive and transmit both on")

    // a received byte only in receive mode
    `HDTU_ASSERT(a_rx_mode, clk, rst_n, out_valid && rx_valid |-> receive_on, "byte strobe outside receive mode")

    // no stale data without the strobe
    `HDTU_ASSERT(a_rx_clear, clk, rst_n, out_valid && !rx_valid |-> rx_data == '0, "receive data set without strobe")

endmodule

bind half_duplex_timed_uart_unit hdtu_port_checker u_hdtu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rx_valid    (rx_valid),
    .rx_data     (rx_data),
    .receive_on  (receive_on),
    .transmit_on (transmit_on)
);

`default_nettype wire

// ===== test/hdtu_checker.sv =====
// word checker for the half-duplex timed serial port: watches the config, input and result
// channels, keeps its own copy of the port state and compares every result word
// depends on hdtu_pkg

module hdtu_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  hdtu_pkg::period_t   cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic                rx_line,
    input  hdtu_pkg::byte_t     tx_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                tx_line,
    input  logic                tx_done,
    input  logic                rx_valid,
    input  hdtu_pkg::byte_t     rx_data,
    input  logic                receive_on,
    input  logic                transmit_on,
    output int                  mismatches,
    output int                  in_flight,
    output int                  bytes_received
);
    import hdtu_pkg::*;

    // shadow of the port registers and periods
    periods_t periods;
    logic     rx_on;
    logic     tx_on;
    byte_t    bit_no;
    byte_t    shifter;
    period_t  tick_timer;
    logic     line_lvl;
    logic     done_lvl;

    // result words still owed by the block, oldest first
    result_t  owed_words[$];

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // advance the shadow state by one input word and queue the result it gives
    task automatic step_port(input opcode_t op, input logic line, input byte_t data);
        logic    strobe;
        byte_t   caught;
        result_t word;
        strobe = 1'b0;
        caught = '0;
        case (op)
            OP_TICK: begin
                if (rx_on || tx_on) begin
                    if (tick_timer > period_t'(1)) begin
                        tick_timer = tick_timer - 1'b1;
                    end else if (line && bit_no == '0) begin
                        // idle line while hunting or idle transmitter: just reload
                        tick_timer = periods.hunt_period;
                    end else if (rx_on) begin
                        if (bit_no == '0) begin
                            // start bit found, line is low here
                            tick_timer = periods.rx_first_period;
                            bit_no     = 8'd1;
                            shifter    = '0;
                        end else begin
                            tick_timer = periods.bit_period;
                            bit_no     = bit_no + 1'b1;
                            if (bit_no <= LAST_DATA_BIT) begin
                                shifter = {line, shifter[7:1]};
                                strobe  = (bit_no == LAST_DATA_BIT);
                                if (strobe)
                                    caught = shifter;
                            end else begin
                                // stop-bit slot, back to hunting
                                tick_timer = periods.hunt_period;
                                bit_no     = '0;
                            end
                        end
                    end else begin
                        tick_timer = periods.bit_period;
                        bit_no     = bit_no - 1'b1;
                        // counter wrapped below zero while idle with a low rx line
                        if (bit_no > LAST_DATA_BIT) begin
                            bit_no  = LAST_DATA_BIT;
                            shifter = STOP_FILL;
                        end
                        if (bit_no > 8'd1) begin
                            line_lvl = shifter[0];
                            shifter  = shifter >> 1;
                        end else begin
                            line_lvl = 1'b1;
                            if (bit_no == '0)
                                done_lvl = 1'b1;
                        end
                    end
                end
            end
            OP_SEND: begin
                // ignored outside transmit mode and while a frame is going out
                if (tx_on && done_lvl) begin
                    tick_timer = periods.tx_start_period;
                    shifter    = data;
                    bit_no     = TX_FRAME_COUNT;
                    line_lvl   = 1'b0;
                    done_lvl   = 1'b0;
                end
            end
            OP_RX_MODE: begin
                rx_on      = 1'b1;
                tx_on      = 1'b0;
                tick_timer = periods.hunt_period;
                bit_no     = '0;
            end
            default: begin
                tx_on    = 1'b1;
                rx_on    = 1'b0;
                bit_no   = '0;
                done_lvl = 1'b1;
            end
        endcase
        word.tx_line     = line_lvl;
        word.tx_done     = done_lvl;
        word.rx_valid    = strobe;
        word.rx_data     = caught;
        word.receive_on  = rx_on;
        word.transmit_on = tx_on;
        owed_words.push_back(word);
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            periods.bit_period      = BIT_PERIOD_RST;
            periods.hunt_period     = HUNT_PERIOD_RST;
            periods.rx_first_period = RX_FIRST_PERIOD_RST;
            periods.tx_start_period = TX_START_PERIOD_RST;
            rx_on      = 1'b0;
            tx_on      = 1'b0;
            bit_no     = '0;
            shifter    = '0;
            tick_timer = HUNT_PERIOD_RST;
            line_lvl   = 1'b1;
            done_lvl   = 1'b0;
            owed_words.delete();
            mismatches     = 0;
            bytes_received = 0;
            in_flight <= 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_BIT_PERIOD:      periods.bit_period      = cfg_data;
                    REG_HUNT_PERIOD:     periods.hunt_period     = cfg_data;
                    REG_RX_FIRST_PERIOD: periods.rx_first_period = cfg_data;
                    default:             periods.tx_start_period = cfg_data;
                endcase
            end
            // result word taken, always an older word than one taken at this edge
            if (out_valid && out_ready) begin
                if (rx_valid)
                    bytes_received++;
                if (owed_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, actual %0h",
                             $time, {tx_line, tx_done, rx_valid, rx_data, receive_on,
                                     transmit_on});
                end else begin
                    want = owed_words.pop_front();
                    check_field("tx_line", want.tx_line, tx_line);
                    check_field("tx_done", want.tx_done, tx_done);
                    check_field("rx_valid", want.rx_valid, rx_valid);
                    check_field("rx_data", want.rx_data, rx_data);
                    check_field("receive_on", want.receive_on, receive_on);
                    check_field("transmit_on", want.transmit_on, transmit_on);
                end
            end
            // input word taken
            if (in_valid && in_ready)
                step_port(opcode_t'(opcode), rx_line, tx_data);
            in_flight <= owed_words.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// top of the serial port test: clock, reset, word stimulus, receiver stalls and verdict
// depends on hdtu_pkg, half_duplex_timed_uart_unit and hdtu_checker

module tb_top;
    import hdtu_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASES       = 9;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    period_t     cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [1:0]  opcode    = '0;
    logic        rx_line   = 1'b1;
    byte_t       tx_data   = '0;
    logic        out_ready = 1'b0;

    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic        tx_line;
    logic        tx_done;
    logic        rx_valid;
    byte_t       rx_data;
    logic        receive_on;
    logic        transmit_on;

    int          mismatches;
    int          in_flight;
    int          bytes_received;

    // stimulus bookkeeping
    int          words_sent       = 0;
    int          settings_applied = 0;
    int          burst_left       = 0;
    int          stall_asks       = 0;
    int          stall_seen       = 0;
    int          cycles           = 0;
    logic        mode_rx          = 1'b0;
    logic        mode_tx          = 1'b0;
    int          sb               = 1;
    int          sh               = 1;
    int          st               = 1;

    half_duplex_timed_uart_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .rx_line     (rx_line),
        .tx_data     (tx_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_line     (tx_line),
        .tx_done     (tx_done),
        .rx_valid    (rx_valid),
        .rx_data     (rx_data),
        .receive_on  (receive_on),
        .transmit_on (transmit_on)
    );

    hdtu_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .rx_line        (rx_line),
        .tx_data        (tx_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_line        (tx_line),
        .tx_done        (tx_done),
        .rx_valid       (rx_valid),
        .rx_data        (rx_data),
        .receive_on     (receive_on),
        .transmit_on    (transmit_on),
        .mismatches     (mismatches),
        .in_flight      (in_flight),
        .bytes_received (bytes_received)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still owed", cycles, in_flight);
        $display("Some tests failed");
        $finish;
    end

    // waveform lengths used to shape frames, kept short for huge periods
    function automatic int shape_len(input period_t p);
        if (p == '0)
            return 1;
        if (p > period_t'(12))
            return 12;
        return int'(p);
    endfunction

    // offer one input word, with bursts and gaps on the sender side
    task automatic push_word(input opcode_t op, input logic line, input byte_t data);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 25);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_line  <= line;
        tx_data  <= data;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        words_sent++;
        if (op == OP_RX_MODE) begin
            mode_rx = 1'b1;
            mode_tx = 1'b0;
        end else if (op == OP_TX_MODE) begin
            mode_tx = 1'b1;
            mode_rx = 1'b0;
        end
    endtask

    // a run of ticks at one receive level
    task automatic hold_level(input logic lvl, input int n);
        for (int i = 0; i < n; i++)
            push_word(OP_TICK, lvl, byte_t'($urandom));
    endtask

    // stop offering and wait until every owed word has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input period_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // new period set, written only with the port idle
    task automatic apply_periods(input period_t bitp, input period_t hunt,
                                 input period_t first, input period_t start);
        settle();
        write_reg(REG_BIT_PERIOD, bitp);
        write_reg(REG_HUNT_PERIOD, hunt);
        write_reg(REG_RX_FIRST_PERIOD, first);
        write_reg(REG_TX_START_PERIOD, start);
        cfg_valid <= 1'b0;
        sb = shape_len(bitp);
        sh = shape_len(hunt);
        st = shape_len(start);
        settings_applied++;
    endtask

    // one phase of mostly well-formed frames with some noise
    task automatic run_phase(input int target);
        int    goal;
        int    pick;
        int    cut;
        int    n;
        byte_t frame;
        goal = words_sent + target;
        while (words_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // receive frame, sometimes cut short
                if (!mode_rx)
                    push_word(OP_RX_MODE, 1'b1, byte_t'($urandom));
                hold_level(1'b1, $urandom_range(0, 2 * sh + 2));
                frame = byte_t'($urandom);
                cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : 9;
                hold_level(1'b0, (sb > sh + 1) ? sb : sh + 1);
                for (int i = 0; i < 8 && i < cut; i++)
                    hold_level(frame[i], sb);
                if (cut == 9)
                    hold_level(1'b1, sb + $urandom_range(0, 2));
            end else if (pick < 80) begin
                // transmit frame, rx line mostly high
                if (!mode_tx)
                    push_word(OP_TX_MODE, 1'b1, byte_t'($urandom));
                push_word(OP_SEND, 1'($urandom), byte_t'($urandom));
                n = st + 10 * sb + $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    push_word(OP_TICK, ($urandom_range(0, 9) != 0), byte_t'($urandom));
            end else begin
                // noise words of any kind
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    push_word(opcode_t'($urandom_range(0, 3)), 1'($urandom),
                              byte_t'($urandom));
            end
        end
    endtask

    // receiver: stall pattern of its own plus long hold-offs on request
    initial begin
        int seg_left;
        int rmode;
        int rk;
        int cyc;
        seg_left = 0;
        rmode    = 0;
        rk       = 2;
        cyc      = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            cyc++;
            if (stall_seen != stall_asks) begin
                stall_seen = stall_asks;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                if (seg_left <= 0) begin
                    rmode    = $urandom_range(0, 3);
                    rk       = $urandom_range(2, 5);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (rmode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    2:       out_ready <= ((cyc % rk) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset periods: ignored words, send, busy send, mode switches
        push_word(OP_TICK, 1'b0, 8'h00);
        push_word(OP_SEND, 1'b1, 8'hFF);
        push_word(OP_TX_MODE, 1'b1, 8'h00);
        push_word(OP_SEND, 1'b1, 8'h00);
        push_word(OP_SEND, 1'b0, 8'hFF);
        push_word(OP_TICK, 1'b1, 8'hFF);
        push_word(OP_RX_MODE, 1'b0, 8'h00);

        // zero hunt period, start bit, then transmit with a low rx line while idle
        apply_periods(period_t'(1), period_t'(0), period_t'(1), period_t'(1));
        push_word(OP_RX_MODE, 1'b1, 8'h00);
        push_word(OP_TICK, 1'b1, 8'h00);
        push_word(OP_TICK, 1'b0, 8'hFF);
        push_word(OP_TICK, 1'b1, 8'h00);
        push_word(OP_TICK, 1'b0, 8'h00);
        push_word(OP_TX_MODE, 1'b0, 8'h00);
        push_word(OP_TICK, 1'b0, 8'h00);
        push_word(OP_TICK, 1'b1, 8'h00);
        push_word(OP_SEND, 1'b1, 8'h5A);
        push_word(OP_TICK, 1'b0, 8'hFF);

        // random phases over several period sets
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_periods('0, '0, '0, '0);
                1: apply_periods(17'h1FFFF, 17'h10000, 17'h1FFFF, 17'h10000);
                2: apply_periods(period_t'(1), period_t'(1), period_t'(1), period_t'(1));
                default: apply_periods(period_t'($urandom_range(1, 5)),
                                       period_t'($urandom_range(0, 3)),
                                       period_t'($urandom_range(1, 7)),
                                       period_t'($urandom_range(1, 6)));
            endcase
            if (ph == 4 || ph == 7)
                stall_asks++;
            run_phase((ph == 1) ? 60 : (ph == 0) ? 180 : 150);
        end

        settle();
        $display("covered %0d input words under %0d period settings", words_sent,
                 settings_applied);
        $display("%0d bytes came out of the receiver, %0d long output hold-offs",
                 bytes_received, stall_asks);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
